>>> hdl/wpu_pkg.sv
// shared widths, register codes and constants for the wolf position update
package wpu_pkg;

  // field widths
  localparam int COORD_W = 16;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 2;

  // packed input item: four coordinates then six fractions
  localparam int IN_W  = 4 * COORD_W + 6 * FRAC_W;
  localparam int OUT_W = COORD_W;

  // fraction bits of the fixed point formats
  localparam int RAND_FRAC = 16;
  localparam int A_FRAC    = 14;

  // configuration register indexes
  typedef enum logic [ADDR_W-1:0] {
    REG_COEF_A = 2'd0,
    REG_LOWER  = 2'd1,
    REG_UPPER  = 2'd2
  } cfg_reg_t;

  // reset values: a = 2.0 in Q2.14, bounds -5 and 5 in Q5.11
  localparam logic        [CFG_W-1:0]   COEF_A_RST = 16'd32768;
  localparam logic signed [COORD_W-1:0] LOWER_RST  = -16'sd10240;
  localparam logic signed [COORD_W-1:0] UPPER_RST  = 16'sd10240;

  // divide by three: floor(m / 3) = (m * ceil(2^25 / 3)) >> 25 for m below 2^24
  localparam int               DIV3_IN_W  = 24;
  localparam int               DIV3_SHIFT = 25;
  localparam logic [DIV3_IN_W-1:0] DIV3_MUL = 24'd11184811;

  // internal widths
  localparam int CA_W   = 18;  // signed A coefficient, Q.14
  localparam int DABS_W = 17;  // unsigned |C*L - x|, Q.11
  localparam int PROD_W = 36;  // signed A*D, Q.25
  localparam int X_W    = 23;  // signed per-leader position
  localparam int SUM_W  = 25;  // signed sum of three positions

endpackage

>>> hdl/wolf_position_update.sv
// grey wolf position update: one coordinate per item, six stage pipeline
//
// Input items arrive on the s_axis channel; each carries the wolf coordinate,
// the alpha, beta and delta leader coordinates of the same dimension and six
// random fractions. For each leader the block forms A = 2*a*r1 - a and
// C = 2*r2, D = |C*L - x| and X = L - A*D, averages the three X values
// (divide by three toward zero) and clamps to the configured bounds. Each
// item yields exactly one result item on the m_axis channel.
// Six register stages, the first loaded at acceptance and the last driving
// m_axis_tvalid; one item is taken every cycle while the receiver keeps
// m_axis_tready high. The stages are: input multiplies, A and |D| forming, A*D
// multiply, leader sum, reciprocal multiply for the divide by three, and
// sign restore with clamp into the output register.
// Each stage holds its item while the next one is full and stalled, so a
// stalled receiver fills the pipeline and then drops s_axis_tready; bubbles
// are squeezed out. Reset empties the pipeline and loads a = 2.0 and bounds
// of -5 and 5. Configuration writes are meant for an idle pipeline; index 3
// is ignored.
module wolf_position_update (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [wpu_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [wpu_pkg::CFG_W-1:0]  cfg_wdata,
  // input items
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // wolf_coord, alpha_coord, beta_coord, delta_coord, rand_a_alpha,
  // rand_c_alpha, rand_a_beta, rand_c_beta, rand_a_delta, rand_c_delta
  input  logic [wpu_pkg::IN_W-1:0]   s_axis_tdata,
  // result items
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // new_coord
  output logic [wpu_pkg::OUT_W-1:0]  m_axis_tdata
);
  import wpu_pkg::*;

  localparam int NSTAGE = 6;
  localparam int NLEAD  = 3;

  // configuration registers
  logic        [CFG_W-1:0]   coef_a;
  logic signed [COORD_W-1:0] pos_min;
  logic signed [COORD_W-1:0] pos_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a  <= COEF_A_RST;
      pos_min <= LOWER_RST;
      pos_max <= UPPER_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COEF_A: coef_a  <= cfg_wdata;
        REG_LOWER:  pos_min <= $signed(cfg_wdata);
        REG_UPPER:  pos_max <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // stage valid bits and enables
  logic [NSTAGE-1:0] stg_valid;
  logic [NSTAGE-1:0] stg_en;

  always_comb begin
    stg_en[NSTAGE-1] = !stg_valid[NSTAGE-1] || m_axis_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      stg_en[k] = !stg_valid[k] || stg_en[k+1];
    end
  end

  assign s_axis_tready = stg_en[0];
  assign m_axis_tvalid = stg_valid[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      if (stg_en[0]) stg_valid[0] <= s_axis_tvalid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (stg_en[k]) stg_valid[k] <= stg_valid[k-1];
      end
    end
  end

  // unpack the input item
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_lead [NLEAD];
  logic        [FRAC_W-1:0]  in_ra   [NLEAD];
  logic        [FRAC_W-1:0]  in_rc   [NLEAD];

  always_comb begin
    in_x = $signed(s_axis_tdata[COORD_W-1:0]);
    for (int i = 0; i < NLEAD; i++) begin
      in_lead[i] = $signed(s_axis_tdata[(i+1)*COORD_W +: COORD_W]);
      in_ra[i]   = s_axis_tdata[4*COORD_W + 2*i*FRAC_W +: FRAC_W];
      in_rc[i]   = s_axis_tdata[4*COORD_W + (2*i+1)*FRAC_W +: FRAC_W];
    end
  end

  // stage 1: a*r1 and r2*L products
  logic        [2*FRAC_W-1:0]  s1_ar   [NLEAD];
  logic signed [2*FRAC_W:0]    s1_cl   [NLEAD];
  logic signed [COORD_W-1:0]   s1_lead [NLEAD];
  logic signed [COORD_W-1:0]   s1_x;
  logic signed [FRAC_W:0]      rc_s    [NLEAD];
  logic signed [2*FRAC_W:0]    cl_prod [NLEAD];

  always_comb begin
    for (int i = 0; i < NLEAD; i++) begin
      rc_s[i]    = $signed({1'b0, in_rc[i]});
      cl_prod[i] = rc_s[i] * in_lead[i];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      s1_x <= in_x;
      for (int i = 0; i < NLEAD; i++) begin
        s1_ar[i]   <= (2*FRAC_W)'(coef_a) * (2*FRAC_W)'(in_ra[i]);
        s1_cl[i]   <= cl_prod[i];
        s1_lead[i] <= in_lead[i];
      end
    end
  end

  // stage 2: A = 2*a*r1 - a and |C*L - x|
  logic signed [CA_W-1:0]    ca_next   [NLEAD];
  logic        [DABS_W-1:0]  dabs_next [NLEAD];
  logic signed [DABS_W+1:0]  d_diff    [NLEAD];
  logic signed [CA_W-1:0]    s2_ca     [NLEAD];
  logic        [DABS_W-1:0]  s2_dabs   [NLEAD];
  logic signed [COORD_W-1:0] s2_lead   [NLEAD];

  always_comb begin
    for (int i = 0; i < NLEAD; i++) begin
      // (2*a*r1) >> 16 equals (a*r1) >> 15
      ca_next[i] = $signed({1'b0, s1_ar[i][2*FRAC_W-1:RAND_FRAC-1]})
                 - $signed({2'b00, coef_a});
      // floor of C*L in Q.11 is the product shifted down by 15
      d_diff[i]  = (DABS_W+2)'($signed(s1_cl[i][2*FRAC_W:RAND_FRAC-1]))
                 - (DABS_W+2)'(s1_x);
      dabs_next[i] = d_diff[i][DABS_W+1] ? DABS_W'(-d_diff[i]) : DABS_W'(d_diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      for (int i = 0; i < NLEAD; i++) begin
        s2_ca[i]   <= ca_next[i];
        s2_dabs[i] <= dabs_next[i];
        s2_lead[i] <= s1_lead[i];
      end
    end
  end

  // stage 3: A*D
  logic signed [PROD_W-1:0]  s3_prod [NLEAD];
  logic signed [COORD_W-1:0] s3_lead [NLEAD];

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      for (int i = 0; i < NLEAD; i++) begin
        s3_prod[i] <= s2_ca[i] * $signed({1'b0, s2_dabs[i]});
        s3_lead[i] <= s2_lead[i];
      end
    end
  end

  // stage 4: X = L - floor(A*D / 2^14), summed over the leaders
  logic signed [X_W-1:0]   x_pos [NLEAD];
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SUM_W-1:0] s4_sum;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NLEAD; i++) begin
      x_pos[i] = X_W'(s3_lead[i]) - X_W'($signed(s3_prod[i][PROD_W-1:A_FRAC]));
      sum_next = sum_next + SUM_W'(x_pos[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[3]) s4_sum <= sum_next;
  end

  // stage 5: magnitude times the reciprocal of three
  logic [DIV3_IN_W-1:0]   mag_next;
  logic [2*DIV3_IN_W-1:0] s5_prod;
  logic [DIV3_IN_W-1:0]   s5_mag;
  logic                   s5_neg;

  assign mag_next = s4_sum[SUM_W-1] ? DIV3_IN_W'(-s4_sum) : DIV3_IN_W'(s4_sum);

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      s5_prod <= (2*DIV3_IN_W)'(mag_next) * (2*DIV3_IN_W)'(DIV3_MUL);
      s5_mag  <= mag_next;
      s5_neg  <= s4_sum[SUM_W-1];
    end
  end

  // stage 6: restore sign, clamp low then high
  localparam int Q_W = 2*DIV3_IN_W - DIV3_SHIFT;

  logic        [Q_W-1:0]       div_q;
  logic signed [DIV3_IN_W-1:0] avg;
  logic signed [DIV3_IN_W-1:0] clamp_lo;
  logic signed [DIV3_IN_W-1:0] clamped;

  always_comb begin
    div_q    = s5_prod[2*DIV3_IN_W-1:DIV3_SHIFT];
    avg      = s5_neg ? -$signed(DIV3_IN_W'(div_q)) : $signed(DIV3_IN_W'(div_q));
    clamp_lo = (avg < DIV3_IN_W'(pos_min)) ? DIV3_IN_W'(pos_min) : avg;
    clamped  = (clamp_lo > DIV3_IN_W'(pos_max)) ? DIV3_IN_W'(pos_max) : clamp_lo;
  end

  always_ff @(posedge clk) begin
    if (stg_en[5]) m_axis_tdata <= clamped[OUT_W-1:0];
  end

  // checks
  logic [Q_W+2:0] div_q3;
  assign div_q3 = (Q_W+3)'(div_q) * (Q_W+3)'(3);

  a_div3_exact: assert property (@(posedge clk) disable iff (rst)
    stg_valid[4] |-> (div_q3 <= (Q_W+3)'(s5_mag)) &&
                     ((Q_W+3)'(s5_mag) - div_q3 < (Q_W+3)'(3)))
    else $error("divide by three out of range");

  a_in_bounds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (pos_min <= pos_max) |->
      ($signed(m_axis_tdata) >= pos_min) && ($signed(m_axis_tdata) <= pos_max))
    else $error("result outside configured bounds");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> stg_valid[0])
    else $error("accepted item did not enter the pipeline");

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    stg_valid[2] && !stg_en[2] |=> stg_valid[2] && $stable(s3_prod[0]))
    else $error("stalled item lost in the multiply stage");

endmodule
